// ===== design/isam_pkg.sv =====
// shared types and constants for the interval scaled add core
// field widths of the request and response and the default datapath width
// no dependencies
package isam_pkg;

   localparam int DEFAULT_WIDTH = 32;
   localparam int COUNT_BITS    = 6;
   localparam int BOUND_BITS    = 32;

   typedef struct packed {
      logic                  action;
      logic [COUNT_BITS-1:0] bit_count;
      logic [BOUND_BITS-1:0] a_low;
      logic [BOUND_BITS-1:0] a_high;
      logic [BOUND_BITS-1:0] b_low;
      logic [BOUND_BITS-1:0] b_high;
      logic [BOUND_BITS-1:0] coefficient;
   } req_type;

   typedef struct packed {
      logic [BOUND_BITS-1:0] result_low;
      logic [BOUND_BITS-1:0] result_high;
   } rsp_type;

endpackage

// ===== design/isam_req_if.sv =====
// request channel: valid/ready handshake with the two operand intervals
// depends on isam_pkg
interface isam_req_if;
   logic                              valid;
   logic                              ready;
   logic                              action;
   logic [isam_pkg::COUNT_BITS-1:0]   bit_count;
   logic [isam_pkg::BOUND_BITS-1:0]   a_low;
   logic [isam_pkg::BOUND_BITS-1:0]   a_high;
   logic [isam_pkg::BOUND_BITS-1:0]   b_low;
   logic [isam_pkg::BOUND_BITS-1:0]   b_high;
   logic [isam_pkg::BOUND_BITS-1:0]   coefficient;

   modport source (output valid, action, bit_count, a_low, a_high, b_low, b_high,
                   coefficient, input ready);
   modport sink (input valid, action, bit_count, a_low, a_high, b_low, b_high,
                 coefficient, output ready);
endinterface

// ===== design/isam_rsp_if.sv =====
// response channel: valid/ready handshake with the enclosing interval
// depends on isam_pkg
interface isam_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [isam_pkg::BOUND_BITS-1:0]   result_low;
   logic [isam_pkg::BOUND_BITS-1:0]   result_high;

   modport source (output valid, result_low, result_high, input ready);
   modport sink (input valid, result_low, result_high, output ready);
endinterface

// ===== design/isam_calc.sv =====
// combinational interval evaluation of a + c*b over n-bit vectors
// depends on isam_pkg
module isam_calc #(
   parameter int WIDTH = isam_pkg::DEFAULT_WIDTH
) (
   input  isam_pkg::req_type req,
   output isam_pkg::rsp_type rsp
);

   localparam int NW = $clog2(WIDTH + 1);
   localparam int PW = 2 * WIDTH;

   logic [NW-1:0]        n;
   logic [WIDTH-1:0]     m, sbit, al, ah, bl, bh, c;
   logic                 sgn;
   logic                 is_add, is_sub;
   logic [WIDTH-1:0]     lo_as, hi_as;
   logic                 sl, sh, rl_t, rh_t, opl, oph;
   logic                 ufl, ufh, ofl, ofh, full_as;
   logic                 neg;
   logic [WIDTH-1:0]     cs, bsel_l, bsel_h, bop_l, bop_h, aop_l, aop_h;
   logic signed [WIDTH:0]     mc, ml, mh;
   logic signed [PW+1:0]      prod_l, prod_h;
   logic [PW-1:0]        big_l, big_h;
   logic [WIDTH-1:0]     ql, qh, rl, rh, ql_inc;
   logic                 keep;
   logic [WIDTH-1:0]     full_lo, full_hi, lo, hi;

   function automatic logic top(input logic [WIDTH-1:0] x, input logic [WIDTH-1:0] s);
      return |(x & s);
   endfunction

   function automatic logic [WIDTH-1:0] sx(input logic [WIDTH-1:0] x,
                                           input logic [WIDTH-1:0] s,
                                           input logic [WIDTH-1:0] mk);
      return top(x, s) ? (x | ~mk) : x;
   endfunction

   always_comb begin
      // operand size clamped to 1..WIDTH
      if (req.bit_count == '0) begin
         n = NW'(1);
      end else if (int'(req.bit_count) > WIDTH) begin
         n = NW'(WIDTH);
      end else begin
         n = NW'(req.bit_count);
      end
   end

   assign m    = {WIDTH{1'b1}} >> (NW'(WIDTH) - n);
   assign sbit = m ^ (m >> 1);
   assign sgn  = req.action;
   assign al   = WIDTH'(req.a_low) & m;
   assign ah   = WIDTH'(req.a_high) & m;
   assign bl   = WIDTH'(req.b_low) & m;
   assign bh   = WIDTH'(req.b_high) & m;
   assign c    = WIDTH'(req.coefficient) & m;

   assign full_lo = sgn ? sbit : '0;
   assign full_hi = sgn ? (m >> 1) : m;

   // coefficient of one or minus one: plain add or subtract
   assign is_add = (c == WIDTH'(1));
   assign is_sub = (c == m);
   assign lo_as  = (is_add ? al + bl : al - bh) & m;
   assign hi_as  = (is_add ? ah + bh : ah - bl) & m;

   assign sl   = top(al, sbit);
   assign sh   = top(ah, sbit);
   assign rl_t = top(lo_as, sbit);
   assign rh_t = top(hi_as, sbit);
   assign opl  = is_add ? top(bl, sbit) : !top(bh, sbit);
   assign oph  = is_add ? top(bh, sbit) : !top(bl, sbit);
   assign ufl  = sl && opl && !rl_t;
   assign ofl  = !sl && !opl && rl_t;
   assign ufh  = sh && oph && !rh_t;
   assign ofh  = !sh && !oph && rh_t;

   always_comb begin
      if (!sgn) begin
         full_as = is_add ? (hi_as < bh && lo_as >= bl) : (al < bh && ah >= bl);
      end else begin
         full_as = (ufl && !ufh) || (ofh && !ofl);
      end
   end

   // general coefficient: exact double-width bounds; a negative coefficient
   // swaps the b bounds, and in unsigned mode c - 2^n equals -(2^n - c)
   assign neg    = top(c, sbit);
   assign cs     = sx(c, sbit, m);
   assign bsel_l = neg ? bh : bl;
   assign bsel_h = neg ? bl : bh;
   assign bop_l  = sgn ? sx(bsel_l, sbit, m) : bsel_l;
   assign bop_h  = sgn ? sx(bsel_h, sbit, m) : bsel_h;
   assign aop_l  = sgn ? sx(al, sbit, m) : al;
   assign aop_h  = sgn ? sx(ah, sbit, m) : ah;

   assign mc = $signed({cs[WIDTH-1], cs});
   assign ml = $signed({sgn & bop_l[WIDTH-1], bop_l});
   assign mh = $signed({sgn & bop_h[WIDTH-1], bop_h});

   assign prod_l = ml * mc;
   assign prod_h = mh * mc;

   assign big_l = {{WIDTH{sgn & aop_l[WIDTH-1]}}, aop_l} + prod_l[PW-1:0];
   assign big_h = {{WIDTH{sgn & aop_h[WIDTH-1]}}, aop_h} + prod_h[PW-1:0];

   assign ql     = WIDTH'(big_l >> n) & m;
   assign qh     = WIDTH'(big_h >> n) & m;
   assign rl     = big_l[WIDTH-1:0] & m;
   assign rh     = big_h[WIDTH-1:0] & m;
   assign ql_inc = (ql + WIDTH'(1)) & m;

   always_comb begin
      if (!sgn) begin
         keep = (ql == qh);
      end else begin
         keep = ((ql == qh) && ((rl ^ sbit) <= (rh ^ sbit))) ||
                ((ql_inc == qh) && top(rl, sbit) && !top(rh, sbit));
      end
   end

   always_comb begin
      if (is_add || is_sub) begin
         lo = full_as ? full_lo : lo_as;
         hi = full_as ? full_hi : hi_as;
      end else begin
         lo = keep ? rl : full_lo;
         hi = keep ? rh : full_hi;
      end
   end

   assign rsp.result_low  = isam_pkg::BOUND_BITS'(lo);
   assign rsp.result_high = isam_pkg::BOUND_BITS'(hi);

endmodule

// ===== design/interval_scaled_add_mod2n_core.sv =====
// top level of the interval scaled add core: request register, evaluation, result register
// depends on isam_pkg, isam_req_if, isam_rsp_if and isam_calc
//
// Computes an enclosing n-bit interval for [a_low,a_high] + coefficient*[b_low,b_high],
// unsigned (action 0) or two's complement (action 1), with n taken from bit_count.
// Channels: req_ch carries one request per valid/ready handshake, rsp_ch returns
// exactly one result per request, in request order.
// Path: an accepted request is held in the request register, evaluated by isam_calc,
// and its result taken into the result register that drives rsp_ch (request register,
// then result register with one evaluation between).
// Throughput: one request per cycle while rsp_ch.ready is high; both multiplies of the
// evaluation run in parallel in the cycle between the two registers.
// Stalls: when rsp_ch.ready is low the result register holds, the request register
// fills behind it, and req_ch.ready drops only once both are occupied.
// Reset: synchronous, active high; clears both valid flags so no result is shown.
// No configuration registers and no state carried from one request to the next.
module interval_scaled_add_mod2n_core #(
   parameter int WIDTH = isam_pkg::DEFAULT_WIDTH
) (
   input  logic         clock,
   input  logic         reset,
   isam_req_if.sink     req_ch,
   isam_rsp_if.source   rsp_ch
);

   logic              s1_valid_ff, s1_valid_in;
   isam_pkg::req_type s1_req_ff, s1_req_in, req_word;
   logic              rsp_valid_ff, rsp_valid_in;
   isam_pkg::rsp_type rsp_ff, rsp_in, calc_rsp;
   logic              advance, req_fire;

   assign advance  = !rsp_valid_ff || rsp_ch.ready;
   assign req_ch.ready = !s1_valid_ff || advance;
   assign req_fire = req_ch.valid && req_ch.ready;

   assign req_word.action      = req_ch.action;
   assign req_word.bit_count   = req_ch.bit_count;
   assign req_word.a_low       = req_ch.a_low;
   assign req_word.a_high      = req_ch.a_high;
   assign req_word.b_low       = req_ch.b_low;
   assign req_word.b_high      = req_ch.b_high;
   assign req_word.coefficient = req_ch.coefficient;

   isam_calc #(.WIDTH(WIDTH)) u_calc (
      .req (s1_req_ff),
      .rsp (calc_rsp)
   );

   always_comb begin
      s1_valid_in  = req_fire ? 1'b1 : (advance ? 1'b0 : s1_valid_ff);
      s1_req_in    = req_fire ? req_word : s1_req_ff;
      rsp_valid_in = advance ? s1_valid_ff : rsp_valid_ff;
      rsp_in       = (advance && s1_valid_ff) ? calc_rsp : rsp_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_req_ff <= s1_req_in;
      rsp_ff    <= rsp_in;
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.result_low  = rsp_ff.result_low;
   assign rsp_ch.result_high = rsp_ff.result_high;

`ifndef SYNTHESIS
   // reset empties the whole pipe
   assert property (@(posedge clock) reset |=> !s1_valid_ff && !rsp_valid_ff)
      else $error("pipeline not empty after reset");

   // an accepted request always lands in the request register
   assert property (@(posedge clock) disable iff (reset) req_fire |=> s1_valid_ff)
      else $error("accepted request lost");

   // a held request moves to the result register when it advances
   assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && advance |=> rsp_valid_ff)
      else $error("request dropped between stages");

   // a blocked request stays put
   assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !advance |=> s1_valid_ff && $stable(s1_req_ff))
      else $error("stalled request overwritten");
`endif

endmodule

// ===== sim/tb_interval_scaled_add_mod2n_core.sv =====
// self-checking testbench for interval_scaled_add_mod2n_core: directed and random requests,
// predicted enclosing intervals checked response by response under random idles and stalls
// depends on isam_pkg, isam_req_if, isam_rsp_if and the core itself
module tb_interval_scaled_add_mod2n_core;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned CORE_WIDTH   = isam_pkg::DEFAULT_WIDTH;
   localparam logic        ACT_UNSIGNED = 1'b0;
   localparam logic        ACT_SIGNED   = 1'b1;

   typedef struct {
      isam_pkg::req_type item;
      bit                drain_first;
   } pending_req_type;

   typedef enum int {RX_ALWAYS, RX_MOSTLY, RX_RARELY, RX_PATTERN} rx_mode_type;

   logic clock = 1'b0;
   logic reset;

   isam_req_if req_ch ();
   isam_rsp_if rsp_ch ();

   interval_scaled_add_mod2n_core dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   pending_req_type   pending_reqs[$];
   isam_pkg::rsp_type expected_intervals[$];
   bit                req_fired;
   int unsigned       burst_left, gap_left;
   int unsigned       rx_cycles_left;
   rx_mode_type       rx_mode;
   int unsigned       fail_count, accepted_count, signed_count, checked_count;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // ---------------------------------------------------------------- prediction

   function automatic int unsigned operand_size(logic [isam_pkg::COUNT_BITS-1:0] bc);
      if (bc == 0)
         return 1;
      if (bc > CORE_WIDTH)
         return CORE_WIDTH;
      return 32'(bc);
   endfunction

   function automatic logic [127:0] widen_signed(logic [63:0] x, int unsigned n);
      logic [127:0] msk;
      msk = (128'd1 << n) - 128'd1;
      return x[n-1] ? ({64'd0, x} | ~msk) : {64'd0, x};
   endfunction

   function automatic isam_pkg::rsp_type predict_interval(isam_pkg::req_type r);
      int unsigned       n;
      logic [63:0]       m, al, ah, bl, bh, c, cn, lo, hi, ql, qh, rl, rh, smin;
      logic [127:0]      wl, wh, cs;
      logic              sgn, add, full, neg;
      logic              ufl, ufh, ofl, ofh, tl, th;
      isam_pkg::rsp_type p;
      n    = operand_size(r.bit_count);
      m    = (64'd1 << n) - 64'd1;
      smin = 64'd1 << (n - 1);
      sgn  = (r.action == ACT_SIGNED);
      al   = {32'd0, r.a_low} & m;
      ah   = {32'd0, r.a_high} & m;
      bl   = {32'd0, r.b_low} & m;
      bh   = {32'd0, r.b_high} & m;
      c    = {32'd0, r.coefficient} & m;
      full = 1'b0;
      if (c == 64'd1 || c == m) begin
         add = (c == 64'd1);
         lo  = (add ? al + bl : al - bh) & m;
         hi  = (add ? ah + bh : ah - bl) & m;
         if (!sgn) begin
            full = add ? (hi < bh && lo >= bl) : (al < bh && ah >= bl);
         end else begin
            // sign of the term added to each bound, after negation for subtract
            tl   = add ? bl[n-1] : !bh[n-1];
            th   = add ? bh[n-1] : !bl[n-1];
            ufl  = al[n-1] && tl && !lo[n-1];
            ufh  = ah[n-1] && th && !hi[n-1];
            ofl  = !al[n-1] && !tl && lo[n-1];
            ofh  = !ah[n-1] && !th && hi[n-1];
            full = (ufl && !ufh) || (ofh && !ofl);
         end
      end else begin
         neg = c[n-1];
         if (!sgn) begin
            if (!neg) begin
               wl = {64'd0, al} + {64'd0, bl} * {64'd0, c};
               wh = {64'd0, ah} + {64'd0, bh} * {64'd0, c};
            end else begin
               cn = (64'd0 - c) & m;
               wl = {64'd0, al} - {64'd0, bh} * {64'd0, cn};
               wh = {64'd0, ah} - {64'd0, bl} * {64'd0, cn};
            end
         end else begin
            cs = widen_signed(c, n);
            wl = widen_signed(al, n) + widen_signed(neg ? bh : bl, n) * cs;
            wh = widen_signed(ah, n) + widen_signed(neg ? bl : bh, n) * cs;
         end
         ql = wl[n +: 64] & m;
         qh = wh[n +: 64] & m;
         rl = wl[63:0] & m;
         rh = wh[63:0] & m;
         lo = rl;
         hi = rh;
         if (!sgn) begin
            full = (ql != qh);
         end else begin
            full = !((ql == qh && (rl ^ smin) <= (rh ^ smin)) ||
                     (((ql + 64'd1) & m) == qh && rl[n-1] && !rh[n-1]));
         end
      end
      if (full) begin
         lo = sgn ? smin : 64'd0;
         hi = sgn ? (m >> 1) : m;
      end
      p.result_low  = lo[31:0];
      p.result_high = hi[31:0];
      return p;
   endfunction

   // ---------------------------------------------------------------- stimulus

   task automatic queue_req(logic act, logic [isam_pkg::COUNT_BITS-1:0] bc,
                            logic [31:0] al, logic [31:0] ah, logic [31:0] bl,
                            logic [31:0] bh, logic [31:0] c, bit drain);
      pending_req_type pr;
      pr.item.action      = act;
      pr.item.bit_count   = bc;
      pr.item.a_low       = al;
      pr.item.a_high      = ah;
      pr.item.b_low       = bl;
      pr.item.b_high      = bh;
      pr.item.coefficient = c;
      pr.drain_first      = drain;
      pending_reqs.push_back(pr);
   endtask

   function automatic logic [31:0] size_mask(int unsigned n);
      logic [63:0] m;
      m = (64'd1 << n) - 64'd1;
      return m[31:0];
   endfunction

   // corners of the n-bit range show up often, plain random values the rest of the time
   function automatic logic [31:0] pick_bound(int unsigned n);
      logic [31:0] m;
      m = size_mask(n);
      case ($urandom_range(0, 7))
         0: return 32'd0;
         1: return m;
         2: return 32'd1 << (n - 1);
         3: return m >> 1;
         4: return $urandom_range(0, 7) & m;
         5: return (m - $urandom_range(0, 7)) & m;
         default: return $urandom & m;
      endcase
   endfunction

   function automatic logic [31:0] partner_bound(logic [31:0] first, int unsigned n);
      case ($urandom_range(0, 3))
         0, 1: return (first + $urandom_range(0, 20)) & size_mask(n);
         2: return pick_bound(n);
         default: return $urandom & size_mask(n);
      endcase
   endfunction

   function automatic logic [31:0] pick_coefficient(int unsigned n);
      logic [31:0] m;
      m = size_mask(n);
      case ($urandom_range(0, 9))
         0, 1: return 32'd1;
         2, 3: return m;
         4: return 32'd0;
         5: return $urandom_range(2, 9) & m;
         6: return (m - $urandom_range(1, 8)) & m;
         7: return 32'd1 << (n - 1);
         default: return $urandom & m;
      endcase
   endfunction

   // bits above n must be ignored by the core
   function automatic logic [31:0] with_noise(logic [31:0] x, int unsigned n);
      if ($urandom_range(0, 4) == 0)
         return x | ($urandom & ~size_mask(n));
      return x;
   endfunction

   task automatic queue_random_reqs(int unsigned count);
      logic [isam_pkg::COUNT_BITS-1:0] bc;
      int unsigned                     n;
      logic [31:0]                     al, ah, bl, bh, c;
      for (int unsigned i = 0; i < count; i++) begin
         case ($urandom_range(0, 9))
            0, 1, 2, 3: bc = isam_pkg::COUNT_BITS'($urandom_range(1, 8));
            4, 5, 6, 7: bc = isam_pkg::COUNT_BITS'($urandom_range(9, 32));
            8: bc = isam_pkg::COUNT_BITS'(32);
            default: bc = isam_pkg::COUNT_BITS'($urandom_range(0, 63));
         endcase
         n  = operand_size(bc);
         al = pick_bound(n);
         ah = partner_bound(al, n);
         bl = pick_bound(n);
         bh = partner_bound(bl, n);
         c  = pick_coefficient(n);
         queue_req($urandom_range(0, 1) ? ACT_SIGNED : ACT_UNSIGNED, bc,
                   with_noise(al, n), with_noise(ah, n), with_noise(bl, n),
                   with_noise(bh, n), with_noise(c, n), (i % 500) == 0);
      end
   endtask

   // ---------------------------------------------------------------- request driver

   always @(negedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else if (!req_ch.valid || req_fired) begin
         if (gap_left > 0) begin
            gap_left--;
            req_ch.valid <= 1'b0;
         end else if (pending_reqs.size() == 0 ||
                      (pending_reqs[0].drain_first && expected_intervals.size() != 0)) begin
            req_ch.valid <= 1'b0;
         end else begin
            req_ch.valid       <= 1'b1;
            req_ch.action      <= pending_reqs[0].item.action;
            req_ch.bit_count   <= pending_reqs[0].item.bit_count;
            req_ch.a_low       <= pending_reqs[0].item.a_low;
            req_ch.a_high      <= pending_reqs[0].item.a_high;
            req_ch.b_low       <= pending_reqs[0].item.b_low;
            req_ch.b_high      <= pending_reqs[0].item.b_high;
            req_ch.coefficient <= pending_reqs[0].item.coefficient;
            void'(pending_reqs.pop_front());
            if (burst_left > 1) begin
               burst_left--;
            end else begin
               gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
               burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                        : $urandom_range(1, 30);
            end
         end
      end
   end

   // ---------------------------------------------------------------- response stalls

   always @(negedge clock) begin
      if (rx_cycles_left == 0) begin
         rx_mode        = rx_mode_type'($urandom_range(0, 3));
         rx_cycles_left = $urandom_range(50, 300);
      end
      rx_cycles_left--;
      case (rx_mode)
         RX_ALWAYS: rsp_ch.ready <= 1'b1;
         RX_MOSTLY: rsp_ch.ready <= ($urandom_range(0, 3) != 0);
         RX_RARELY: rsp_ch.ready <= ($urandom_range(0, 3) == 0);
         default:   rsp_ch.ready <= ((rx_cycles_left % 5) < 3);
      endcase
   end

   // ---------------------------------------------------------------- monitor and checker

   always @(posedge clock) begin : response_check
      isam_pkg::req_type seen;
      isam_pkg::rsp_type want;
      if (reset) begin
         req_fired <= 1'b0;
      end else begin
         req_fired <= req_ch.valid && req_ch.ready;
         if (req_ch.valid && req_ch.ready) begin
            seen.action      = req_ch.action;
            seen.bit_count   = req_ch.bit_count;
            seen.a_low       = req_ch.a_low;
            seen.a_high      = req_ch.a_high;
            seen.b_low       = req_ch.b_low;
            seen.b_high      = req_ch.b_high;
            seen.coefficient = req_ch.coefficient;
            expected_intervals.push_back(predict_interval(seen));
            accepted_count++;
            if (seen.action == ACT_SIGNED)
               signed_count++;
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_intervals.size() == 0) begin
               $error("response with no request outstanding: low %h high %h",
                      rsp_ch.result_low, rsp_ch.result_high);
               fail_count++;
            end else begin
               want = expected_intervals.pop_front();
               checked_count++;
               if (rsp_ch.result_low !== want.result_low) begin
                  $error("result_low: expected %h, actual %h",
                         want.result_low, rsp_ch.result_low);
                  fail_count++;
               end
               if (rsp_ch.result_high !== want.result_high) begin
                  $error("result_high: expected %h, actual %h",
                         want.result_high, rsp_ch.result_high);
                  fail_count++;
               end
            end
         end
      end
   end

   // ---------------------------------------------------------------- sequence

   initial begin
      reset              = 1'b1;
      req_ch.valid       = 1'b0;
      req_ch.action      = ACT_UNSIGNED;
      req_ch.bit_count   = '0;
      req_ch.a_low       = '0;
      req_ch.a_high      = '0;
      req_ch.b_low       = '0;
      req_ch.b_high      = '0;
      req_ch.coefficient = '0;
      rsp_ch.ready       = 1'b0;

      // one-bit operands with a coefficient of one add
      queue_req(ACT_UNSIGNED, 6'd1, 32'h0, 32'h1, 32'h0, 32'h1, 32'h1, 1'b0);
      queue_req(ACT_SIGNED,   6'd1, 32'h1, 32'h0, 32'h1, 32'h0, 32'h1, 1'b0);
      // full-width extremes for add and subtract
      queue_req(ACT_UNSIGNED, 6'd32, 32'h0, 32'hffff_ffff, 32'h0, 32'hffff_ffff, 32'h1,
                1'b0);
      queue_req(ACT_SIGNED,   6'd32, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000,
                32'h7fff_ffff, 32'hffff_ffff, 1'b0);
      // subtract without and with a one-sided wrap
      queue_req(ACT_UNSIGNED, 6'd8, 32'h10, 32'h20, 32'h05, 32'h08, 32'hff, 1'b0);
      queue_req(ACT_UNSIGNED, 6'd8, 32'h02, 32'h20, 32'h05, 32'h08, 32'hff, 1'b0);
      // add with wrap on the high side only
      queue_req(ACT_UNSIGNED, 6'd8, 32'hf0, 32'hfe, 32'h05, 32'h20, 32'h01, 1'b0);
      // signed overflow high only, underflow low only
      queue_req(ACT_SIGNED, 6'd8, 32'h70, 32'h7f, 32'h01, 32'h10, 32'h01, 1'b0);
      queue_req(ACT_SIGNED, 6'd8, 32'h80, 32'h90, 32'h01, 32'h02, 32'hff, 1'b0);
      // size zero counts as one, oversize counts as the full width
      queue_req(ACT_UNSIGNED, 6'd0, 32'hffff_ffff, 32'hffff_fffe, 32'h1, 32'h0, 32'h3,
                1'b0);
      queue_req(ACT_SIGNED, 6'd63, 32'h0000_1234, 32'h0001_0000, 32'hffff_fff0,
                32'h0000_0010, 32'h1234_5678, 1'b0);
      queue_req(ACT_UNSIGNED, 6'd33, 32'h0000_0100, 32'h0000_0200, 32'h0000_0003,
                32'h0000_0009, 32'h0001_0001, 1'b0);
      // operand bits above the size
      queue_req(ACT_UNSIGNED, 6'd4, 32'hffff_fff3, 32'h1234_5675, 32'habcd_ef01,
                32'h0000_ff02, 32'hffff_0003, 1'b0);
      // bounds given in reverse order
      queue_req(ACT_UNSIGNED, 6'd16, 32'h9000, 32'h1000, 32'h0030, 32'h0010, 32'h0005,
                1'b0);
      queue_req(ACT_SIGNED,   6'd16, 32'h7000, 32'h9000, 32'h0004, 32'h0002, 32'h0003,
                1'b0);
      // zero coefficient and plain products
      queue_req(ACT_UNSIGNED, 6'd12, 32'h005, 32'h100, 32'hfff, 32'h000, 32'h000, 1'b0);
      queue_req(ACT_UNSIGNED, 6'd16, 32'h0100, 32'h0200, 32'h0003, 32'h0007, 32'h0010,
                1'b0);
      // negative coefficient in unsigned mode, with and without a quotient change
      queue_req(ACT_UNSIGNED, 6'd16, 32'h1000, 32'h2000, 32'h0003, 32'h0007, 32'hfff0,
                1'b0);
      queue_req(ACT_UNSIGNED, 6'd16, 32'h0000, 32'h0010, 32'h0001, 32'h0002, 32'h8000,
                1'b0);
      // signed products: equal quotients, high quotient one above low, negative c
      queue_req(ACT_SIGNED, 6'd8, 32'hfe, 32'h05, 32'h01, 32'h02, 32'h03, 1'b0);
      queue_req(ACT_SIGNED, 6'd8, 32'hff, 32'h05, 32'h00, 32'h00, 32'h03, 1'b0);
      queue_req(ACT_SIGNED, 6'd16, 32'h0010, 32'h0020, 32'hfffe, 32'h0003, 32'hfffd, 1'b0);
      queue_req(ACT_SIGNED, 6'd32, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000,
                32'h8000_0000, 32'h8000_0000, 1'b0);
      queue_req(ACT_UNSIGNED, 6'd32, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff,
                32'hffff_ffff, 32'h7fff_ffff, 1'b0);
      queue_req(ACT_SIGNED, 6'd32, 32'h0, 32'h0, 32'h4000_0000, 32'h3fff_ffff, 32'h2, 1'b0);

      queue_random_reqs(1850);

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (pending_reqs.size() != 0 || req_ch.valid || expected_intervals.size() != 0)
         @(negedge clock);
      repeat (8) @(negedge clock);

      $display("covered %0d requests (%0d signed, %0d unsigned), %0d responses compared",
               accepted_count, signed_count, accepted_count - signed_count, checked_count);
      if (fail_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("CHECKS FAILED");
      $finish;
   end

endmodule

// ===== sim.f =====
design/isam_pkg.sv
design/isam_req_if.sv
design/isam_rsp_if.sv
design/isam_calc.sv
design/interval_scaled_add_mod2n_core.sv
sim/tb_interval_scaled_add_mod2n_core.sv
